FILE: design/mpo_pkg.sv
// Shared types, register indexes, waveform codes and fixed-point constants
// for the multiwave phase oscillator. No dependencies; the top level
// multiwave_phase_oscillator uses it by scoped names.
`default_nettype none

package mpo_pkg;

  // Register indexes of the configuration write port.
  localparam logic [1:0] RegPhaseStep  = 2'd0;
  localparam logic [1:0] RegAmplitude  = 2'd1;
  localparam logic [1:0] RegWaveSelect = 2'd2;
  localparam logic [1:0] RegEnable     = 2'd3;

  // Waveform codes held in the wave_select register.
  localparam logic [1:0] WaveSine     = 2'd0;
  localparam logic [1:0] WaveSquare   = 2'd1;
  localparam logic [1:0] WaveSawtooth = 2'd2;
  localparam logic [1:0] WaveTriangle = 2'd3;

  // Reset value of the gain: unity in unsigned Q1.15.
  localparam logic [15:0] AmplitudeReset = 16'h8000;

  // Waveform values are Q1.30 in 32 signed bits.
  localparam logic signed [31:0] Q30One    = 32'sh4000_0000;
  localparam logic signed [31:0] Q30MinOne = 32'shC000_0000;
  // Three in Q1.30 needs one extra bit to stay positive.
  localparam logic signed [32:0] Q30Three  = 33'sh0_C000_0000;

  // Pi in Q2.30, rounded.
  localparam logic [63:0] PiQ30 = 64'd3373259426;

  // Taylor series divisors (2k)(2k+1) for k = 1..6.
  localparam int unsigned TaylorDiv [6] = '{6, 20, 42, 72, 110, 156};

  typedef logic signed [31:0] wave_t;

  // sin(2*pi*t/2^32) in Q1.30, by quadrant folding and a truncating
  // fixed-point Taylor series up to the x^13 term. Used only while
  // building the sine ROM at elaboration.
  function automatic wave_t sine_q30(input logic [31:0] t);
    logic                neg;
    logic [63:0]         q;
    logic [63:0]         x;
    logic [63:0]         x2;
    logic [63:0]         term;
    logic signed [63:0]  sum;
    neg = t[31];
    q   = {33'd0, t[30:0]};
    if (q > 64'h4000_0000) begin
      q = 64'h8000_0000 - q;
    end
    x    = (q * PiQ30) >> 31;
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      term = term / 64'(TaylorDiv[k-1]);
      if ((k % 2) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum > 64'sh4000_0000) begin
      sum = 64'sh4000_0000;
    end
    if (sum < 64'sd0) begin
      sum = 64'sd0;
    end
    return neg ? -sum[31:0] : sum[31:0];
  endfunction

endpackage

`default_nettype wire

FILE: design/multiwave_phase_oscillator.sv
// Multiwave phase oscillator: phase accumulator, sine ROM, gain multiplier
// and rounding/saturation in a three-stage pipeline. Depends on mpo_pkg.
`default_nettype none

// Direct digital synthesis tone source. Every transfer on the input stream
// is one sample tick and yields exactly one signed sample on the output
// stream, taken from the current 32-bit phase, after which the phase
// advances by phase_step (wrapping modulo one cycle). Bit 0 of the input
// data restarts the phase at zero before the sample is made. Sine, square,
// sawtooth and triangle are selectable; the value is scaled by an unsigned Q1.15
// gain with rounding and saturated to SAMPLE_WIDTH bits. While disabled the
// output is zero and the phase is held at zero. The block takes one tick per
// clock cycle while input ready is high; a sample is presented once its tick
// has passed the three register stages: the registered sine ROM read, the
// gain multiplier stage and the output register. Input ready drops only when
// the output is held by its consumer and the pipeline behind it is full.
// SINE_TABLE_DEPTH must be a power of two; the ROM is built at elaboration.
// Configuration must be written only while no tick is in flight; the block
// itself does not enforce this.
module multiwave_phase_oscillator #(
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int SAMPLE_WIDTH     = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port.
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  // Tick stream. tdata: [0] restart_phase, [7:1] zero.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // Sample stream. tdata: [SAMPLE_WIDTH-1:0] sample, upper bits zero.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH);
  localparam int Sh   = 46 - SAMPLE_WIDTH;

  localparam logic signed [47:0] RoundBias = 48'sd1 <<< (Sh - 1);
  localparam logic signed [47:0] SatMax    = (48'sd1 <<< (SAMPLE_WIDTH - 1)) - 48'sd1;
  localparam logic signed [47:0] SatMin    = -(48'sd1 <<< (SAMPLE_WIDTH - 1));

  // Sine ROM, one Q1.30 entry per table index.
  typedef logic signed [31:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      rom[i] = mpo_pkg::sine_q30(32'(i) << (32 - IdxW));
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

  // Configuration registers and phase accumulator.
  logic [31:0] step_q;
  logic [15:0] amp_q;
  logic [1:0]  wave_sel_q;
  logic        en_q;
  logic [31:0] acc_q, acc_d;

  // Pipeline stage registers.
  logic                v1_q, v2_q, v3_q;
  logic [31:0]         ph1_q;
  logic                en1_q;
  logic signed [31:0]  rom_q;
  logic signed [47:0]  prod_q, prod_d;
  logic [SAMPLE_WIDTH-1:0] out_q, out_d;

  logic               rdy1, rdy2, rdy3;
  logic               s_fire;
  logic               restart;
  logic [31:0]        base_phase;
  logic signed [31:0] wave;
  logic signed [47:0] rnd;
  logic signed [47:0] shr;

  // Stage advance: a stage loads when it is empty or its item moves on.
  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign restart       = s_axis_tdata[0];

  // Phase used for this tick, and the accumulator update.
  always_comb begin
    base_phase = (!en_q || restart) ? 32'd0 : acc_q;
    acc_d      = acc_q;
    if (cfg_we_i && (cfg_idx_i == mpo_pkg::RegEnable) && !cfg_data_i[0]) begin
      acc_d = 32'd0;
    end else if (s_fire) begin
      acc_d = en_q ? (base_phase + step_q) : 32'd0;
    end
  end

  // Configuration writes and the phase accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= 32'd0;
      amp_q      <= mpo_pkg::AmplitudeReset;
      wave_sel_q <= mpo_pkg::WaveSine;
      en_q       <= 1'b0;
      acc_q      <= 32'd0;
    end else begin
      acc_q <= acc_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mpo_pkg::RegPhaseStep:  step_q     <= cfg_data_i;
          mpo_pkg::RegAmplitude:  amp_q      <= cfg_data_i[15:0];
          mpo_pkg::RegWaveSelect: wave_sel_q <= cfg_data_i[1:0];
          mpo_pkg::RegEnable:     en_q       <= cfg_data_i[0];
          default:                ;
        endcase
      end
    end
  end

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= s_axis_tvalid;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Stage 1: capture the phase and read the sine ROM.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      ph1_q <= base_phase;
      en1_q <= en_q;
      rom_q <= SineRom[base_phase[31 -: IdxW]];
    end
  end

  // Stage 2: waveform selection and gain multiply.
  always_comb begin
    unique case (wave_sel_q)
      mpo_pkg::WaveSine:     wave = rom_q;
      mpo_pkg::WaveSquare:   wave = ph1_q[31] ? mpo_pkg::Q30MinOne : mpo_pkg::Q30One;
      mpo_pkg::WaveSawtooth: wave = $signed({1'b0, ph1_q[31:1]}) - mpo_pkg::Q30One;
      mpo_pkg::WaveTriangle: begin
        if (!ph1_q[31]) begin
          wave = $signed(ph1_q) - mpo_pkg::Q30One;
        end else begin
          wave = 32'(mpo_pkg::Q30Three - $signed({1'b0, ph1_q}));
        end
      end
      default:               wave = 32'sd0;
    endcase
    if (!en1_q) begin
      wave = 32'sd0;
    end
    prod_d = wave * $signed({1'b0, amp_q});
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && rdy2) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: round to nearest (ties up), shift down and saturate.
  always_comb begin
    rnd = prod_q + RoundBias;
    shr = rnd >>> Sh;
    if (shr > SatMax) begin
      out_d = SatMax[SAMPLE_WIDTH-1:0];
    end else if (shr < SatMin) begin
      out_d = SatMin[SAMPLE_WIDTH-1:0];
    end else begin
      out_d = shr[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v2_q && rdy3) begin
      out_q <= out_d;
    end
  end

  // Output transfer, sample in the low bits and zeros above.
  assign m_axis_tvalid = v3_q;
  always_comb begin
    m_axis_tdata                     = '0;
    m_axis_tdata[SAMPLE_WIDTH-1:0]   = out_q;
  end

`ifndef SYNTHESIS
  // The phase stays at zero while the tone is disabled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |=> (acc_q == 32'd0))
    else $error("phase accumulator left zero while disabled");

  // A free-running tick advances the phase by exactly one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && en_q && !restart) |=> (acc_q == $past(acc_q + step_q)))
    else $error("phase did not advance by one step");

  // An empty output register never blocks a new tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  // A tick taken while disabled carries a zero product.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && rdy2 && !en1_q) |=> (prod_q == 48'sd0))
    else $error("disabled tick produced a nonzero product");
`endif

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the multiwave phase oscillator: stream-driven
// ticks, a built-in sample predictor and per-phase register settings.
// Depends on mpo_pkg and multiwave_phase_oscillator.
`timescale 1ns / 1ps

module testbench;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SAMPLE_WIDTH     = 16;
  localparam int TABLE_BITS       = $clog2(SINE_TABLE_DEPTH);
  localparam int GAIN_SHIFT       = 46 - SAMPLE_WIDTH;
  localparam int RANDOM_TICKS     = 800;
  localparam int DRAIN_CYCLES     = 8;

  localparam logic signed [63:0] UNIT_Q30   = 64'sd1073741824;
  localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (GAIN_SHIFT - 1);
  localparam logic signed [63:0] SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam logic signed [63:0] SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));
  localparam logic [63:0]        PI_Q30     = 64'd3373259426;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [1:0]  cfg_idx_i     = 2'd0;
  logic [31:0] cfg_data_i    = 32'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [0] restart_phase, [7:1] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [15:0] sample

  multiwave_phase_oscillator #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predictor copy of the registers and the phase accumulator.
  logic [31:0] osc_step  = 32'd0;
  logic [15:0] osc_gain  = 16'h8000;
  logic [1:0]  osc_wave  = mpo_pkg::WaveSine;
  logic        osc_on    = 1'b0;
  logic [31:0] osc_phase = 32'd0;

  logic        pending_restarts [$];
  logic [15:0] expected_samples [$];

  int mismatch_count  = 0;
  int samples_checked = 0;
  int ticks_queued    = 0;
  int settings_used   = 0;
  int tick_gap        = 0;
  int sample_stall    = 0;
  int tick_idle_mode  = 0;
  int sample_idle_mode = 0;

  // Sine of a table angle t (fraction of a cycle in 2^-32 units), Q1.30.
  // Fold into the first quadrant, then sum the truncated Taylor series.
  function automatic logic signed [63:0] sine_entry(input logic [31:0] t);
    logic [63:0]        folded;
    logic [63:0]        angle;
    logic [63:0]        angle_sq;
    logic [63:0]        term;
    logic [63:0]        divisor;
    logic signed [63:0] acc;
    folded = {33'd0, t[30:0]};
    if (folded > 64'h4000_0000) begin
      folded = 64'h8000_0000 - folded;
    end
    angle    = (folded * PI_Q30) >> 31;
    angle_sq = (angle * angle) >> 30;
    term     = angle;
    acc      = $signed(angle);
    for (int k = 1; k <= 6; k++) begin
      divisor = 64'((2 * k) * (2 * k + 1));
      term    = ((term * angle_sq) >> 30) / divisor;
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
    end
    if (acc > UNIT_Q30) begin
      acc = UNIT_Q30;
    end
    if (acc < 0) begin
      acc = 0;
    end
    return t[31] ? -acc : acc;
  endfunction

  // Waveform value in Q1.30 at phase p for the selected shape.
  function automatic logic signed [63:0] waveform_q30(input logic [31:0] p);
    logic signed [63:0] pv;
    logic [31:0]        table_angle;
    pv          = $signed({32'd0, p});
    table_angle = (p >> (32 - TABLE_BITS)) << (32 - TABLE_BITS);
    case (osc_wave)
      mpo_pkg::WaveSine:     return sine_entry(table_angle);
      mpo_pkg::WaveSquare:   return p[31] ? -UNIT_Q30 : UNIT_Q30;
      mpo_pkg::WaveSawtooth: return (pv >>> 1) - UNIT_Q30;
      default:               return p[31] ? 3 * UNIT_Q30 - pv : pv - UNIT_Q30;
    endcase
  endfunction

  // Sample for one tick, then advance the phase; while disabled, zero with the phase held at zero.
  function automatic logic [15:0] predict_sample(input logic restart);
    logic signed [63:0] scaled;
    if (!osc_on) begin
      osc_phase = 32'd0;
      return 16'd0;
    end
    if (restart) begin
      osc_phase = 32'd0;
    end
    scaled = waveform_q30(osc_phase) * $signed({48'd0, osc_gain}) + ROUND_HALF;
    scaled = scaled >>> GAIN_SHIFT;
    if (scaled > SAMPLE_MAX) begin
      scaled = SAMPLE_MAX;
    end else if (scaled < SAMPLE_MIN) begin
      scaled = SAMPLE_MIN;
    end
    osc_phase = osc_phase + osc_step;
    return scaled[15:0];
  endfunction

  // Idle length for either side: mostly none, some short, a few long.
  function automatic int draw_gap(input int mode);
    int r;
    r = $urandom_range(0, 99);
    if (mode == 0 || r < 100 - 15 * mode) begin
      return 0;
    end
    if (r < 96) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Tick driver: presents queued ticks and predicts each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'd0;
      tick_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_samples.push_back(predict_sample(s_axis_tdata[0]));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tick_gap > 0) begin
          tick_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_restarts.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'd0, pending_restarts.pop_front()};
          tick_gap = draw_gap(tick_idle_mode);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sample monitor: random back-pressure and comparison with the oldest
  // expected sample.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sample_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t: unexpected sample transfer: expected none, got %0d",
                   $time, $signed(m_axis_tdata));
          mismatch_count++;
        end else begin
          if (m_axis_tdata !== expected_samples[0]) begin
            $display("%0t: sample mismatch: expected %0d, got %0d", $time,
                     $signed(expected_samples[0]), $signed(m_axis_tdata));
            mismatch_count++;
          end
          void'(expected_samples.pop_front());
          samples_checked++;
        end
      end
      if (sample_stall > 0) begin
        sample_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sample_stall = draw_gap(sample_idle_mode);
      end
    end
  end

  // Register write; the predictor follows at once since no tick is in flight.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mpo_pkg::RegPhaseStep:  osc_step = value;
      mpo_pkg::RegAmplitude:  osc_gain = value[15:0];
      mpo_pkg::RegWaveSelect: osc_wave = value[1:0];
      default: begin
        osc_on = value[0];
        if (!value[0]) begin
          osc_phase = 32'd0;
        end
      end
    endcase
  endtask

  // Wait until every tick is accepted and every sample has come back.
  task automatic wait_idle();
    while (pending_restarts.size() != 0 || s_axis_tvalid ||
           expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // One setting of all registers followed by a burst of ticks.
  task automatic run_phase(input logic [31:0] step, input logic [15:0] gain,
                           input logic [1:0] wave, input logic on, input int count,
                           input int restart_pct);
    wait_idle();
    write_reg(mpo_pkg::RegPhaseStep, step);
    write_reg(mpo_pkg::RegAmplitude, {16'd0, gain});
    write_reg(mpo_pkg::RegWaveSelect, {30'd0, wave});
    write_reg(mpo_pkg::RegEnable, {31'd0, on});
    settings_used++;
    for (int i = 0; i < count; i++) begin
      pending_restarts.push_back($urandom_range(0, 99) < restart_pct);
    end
    ticks_queued += count;
  endtask

  // Stimulus: directed settings first, then random settings and bursts.
  initial begin
    int directed_ticks;
    int step_pick;
    int gain_pick;
    logic [31:0] step;
    logic [15:0] gain;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Disabled: silence whatever the restart flag says.
    run_phase(32'h1234_5678, 16'h8000, mpo_pkg::WaveSine, 1'b0, 2, 50);
    // Quarter-cycle steps through the sine peaks; unity gain saturates high.
    run_phase(32'h4000_0000, 16'h8000, mpo_pkg::WaveSine, 1'b1, 5, 0);
    // Square at nearly twice unity gain, saturating both ways.
    run_phase(32'h8000_0000, 16'hFFFF, mpo_pkg::WaveSquare, 1'b1, 3, 0);
    // Largest step wraps the phase on every tick that starts from a nonzero phase.
    run_phase(32'hFFFF_FFFF, 16'h8000, mpo_pkg::WaveSawtooth, 1'b1, 3, 50);
    run_phase(32'h2000_0000, 16'h4000, mpo_pkg::WaveTriangle, 1'b1, 5, 20);
    // Turning the tone off and on again must clear the phase.
    wait_idle();
    write_reg(mpo_pkg::RegEnable, 32'd0);
    run_phase(32'h1000_0000, 16'h8000, mpo_pkg::WaveTriangle, 1'b1, 2, 0);
    // Zero gain.
    run_phase(32'h0000_0001, 16'h0000, mpo_pkg::WaveSine, 1'b1, 2, 0);
    directed_ticks = ticks_queued;

    while (ticks_queued - directed_ticks < RANDOM_TICKS) begin
      step_pick = $urandom_range(0, 9);
      case (step_pick)
        0:       step = 32'd0;
        1:       step = 32'd1;
        2:       step = 32'hFFFF_FFFF;
        3:       step = 32'h8000_0000;
        4, 5:    step = $urandom_range(1, 1 << 20);
        default: step = $urandom;
      endcase
      gain_pick = $urandom_range(0, 7);
      case (gain_pick)
        0:       gain = 16'h0000;
        1:       gain = 16'h8000;
        2:       gain = 16'hFFFF;
        3:       gain = 16'($urandom_range(32769, 65535));
        default: gain = 16'($urandom_range(0, 32768));
      endcase
      tick_idle_mode   = $urandom_range(0, 3);
      sample_idle_mode = $urandom_range(0, 3);
      run_phase(step, gain, 2'($urandom_range(0, 3)), $urandom_range(0, 9) != 0,
                $urandom_range(8, 60), ($urandom_range(0, 2) == 0) ? 0 :
                ($urandom_range(0, 1) == 0 ? 5 : 50));
    end

    wait_idle();
    if (expected_samples.size() != 0) begin
      $display("%0t: %0d expected samples never arrived", $time,
               expected_samples.size());
      mismatch_count++;
    end
    $display("Sent %0d ticks (%0d directed) under %0d register settings,",
             ticks_queued, directed_ticks, settings_used);
    $display("all four waveforms, gain past unity and phase wrap; %0d samples checked.",
             samples_checked);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: sim.f
design/mpo_pkg.sv
design/multiwave_phase_oscillator.sv
dv/testbench.sv
